>>> design/mple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mple_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   // item codes
   localparam logic [1:0] MODE_RX   = 2'd0;
   localparam logic [1:0] MODE_SEND = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   // result codes
   localparam logic [1:0] KIND_DELIVER  = 2'd0;
   localparam logic [1:0] KIND_TX       = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
   localparam logic [1:0] KIND_OVERFLOW = 2'd3;

   // command codes
   localparam logic [2:0] CMD_ACK    = 3'd0;
   localparam logic [2:0] CMD_REFUSE = 3'd1;
   localparam logic [2:0] CMD_REPLY  = 3'd4;
   localparam logic [9:0] ACK_VAL    = 10'h3ff;

   // register indexes
   localparam logic CFG_RETRY_INTERVAL = 1'b0;
   localparam logic CFG_RETRY_LIMIT    = 1'b1;

   localparam logic [5:0] RETRY_INTERVAL_RESET = 6'd1;
   localparam logic [7:0] RETRY_LIMIT_RESET    = 8'd60;
   localparam logic [5:0] IDLE_MAX             = 6'd63;
   localparam logic [7:0] RETRY_MAX            = 8'd255;

   localparam logic [7:0] START_MASK = 8'hfc;
   localparam logic [7:0] TOP_BIT    = 8'h80;
   localparam logic [7:0] CMD_BIT3   = 8'h08;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PW    = $clog2(RSP_DEPTH);
   localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  rx_count;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic        my_seq;
      logic        peer_seq;
      logic        awaiting;
      logic [5:0]  idle_ticks;
      logic [7:0]  retry_count;
      logic [31:0] last_sent;
   } link_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  rx_cmd;
      logic [9:0]  rx_val;
      logic [31:0] tx_packet;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic        push;
      logic        pop;
      logic [12:0] wdata;
   } queue_ctrl_type;

   typedef struct packed {
      logic        empty;
      logic        full;
      logic [12:0] head;
   } queue_stat_type;

endpackage

`default_nettype wire

>>> design/mple_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mple_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] rx_byte;
   logic [2:0] send_cmd;
   logic [9:0] send_val;

   modport source (output valid, output mode, output rx_byte, output send_cmd,
                   output send_val, input ready);
   modport sink (input valid, input mode, input rx_byte, input send_cmd,
                 input send_val, output ready);
endinterface

`default_nettype wire

>>> design/mple_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mple_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  rx_cmd;
   logic [9:0]  rx_val;
   logic [31:0] tx_packet;
   logic        last;

   modport source (output valid, output kind, output rx_cmd, output rx_val,
                   output tx_packet, output last, input ready);
   modport sink (input valid, input kind, input rx_cmd, input rx_val,
                 input tx_packet, input last, output ready);
endinterface

`default_nettype wire

>>> design/mple_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mple_core (
   input  wire [1:0]                  mode,
   input  wire [7:0]                  rx_byte,
   input  wire [2:0]                  send_cmd,
   input  wire [9:0]                  send_val,
   input  wire [5:0]                  retry_interval,
   input  wire [7:0]                  retry_limit,
   input  wire mple_pkg::link_state_type st,
   input  wire mple_pkg::queue_stat_type q_stat,
   output mple_pkg::link_state_type   nxt,
   output mple_pkg::queue_ctrl_type   q_ctrl,
   output logic [1:0]                 res_n,
   output mple_pkg::rsp_item_type     res_first,
   output mple_pkg::rsp_item_type     res_second
);

   logic [7:0]  sum8;
   logic [7:0]  chk;
   logic        pseq;
   logic        pack;
   logic [2:0]  pcmd;
   logic [9:0]  pval;
   logic        pkt_ok;
   logic        dlv, want_drain, want_tx, flip, clr, retx, tmo, ovf, tx_go, oth_go;
   logic [2:0]  tx_cmd;
   logic [9:0]  tx_val;
   logic        my_mid, my_new, peer_new;
   logic [5:0]  idle_new;
   logic [7:0]  retry_new;
   logic [7:0]  b0, b1, b2, b3;
   logic [31:0] pkt;
   mple_pkg::rsp_item_type dlv_item, oth_item;

   assign sum8 = st.byte0 + st.byte2 + rx_byte;
   assign chk  = sum8 | mple_pkg::TOP_BIT;
   assign pseq = st.byte0[0];
   assign pack = st.byte0[1];
   assign pcmd = st.byte2[6:4];
   assign pval = {st.byte2[2:0], rx_byte[6:0]};

   always_comb begin
      nxt        = st;
      pkt_ok     = 1'b0;
      dlv        = 1'b0;
      want_drain = 1'b0;
      want_tx    = 1'b0;
      flip       = 1'b0;
      clr        = 1'b0;
      retx       = 1'b0;
      tmo        = 1'b0;
      ovf        = 1'b0;
      tx_cmd     = mple_pkg::CMD_ACK;
      tx_val     = mple_pkg::ACK_VAL;
      peer_new   = st.peer_seq;
      idle_new   = st.idle_ticks;
      retry_new  = st.retry_count;
      q_ctrl     = '0;

      case (mode)
         mple_pkg::MODE_RX: begin
            if (st.rx_count == 2'd0 || !rx_byte[7]) begin
               nxt.rx_count = 2'd0;
               if ((rx_byte & mple_pkg::START_MASK) == 8'd0) begin
                  nxt.byte0    = rx_byte;
                  nxt.rx_count = 2'd1;
               end
            end else if (st.rx_count == 2'd1) begin
               nxt.byte1    = rx_byte;
               nxt.rx_count = 2'd2;
            end else if (st.rx_count == 2'd2) begin
               nxt.byte2    = rx_byte;
               nxt.rx_count = 2'd3;
            end else begin
               nxt.rx_count = 2'd0;
               pkt_ok = (chk == st.byte1) && ((st.byte2 & mple_pkg::CMD_BIT3) == 8'd0);
            end

            if (pkt_ok) begin
               if (!st.awaiting) begin
                  if (pcmd != mple_pkg::CMD_ACK && pack == st.my_seq) begin
                     if (pseq == st.peer_seq) begin
                        // duplicate: answer with an ack, or send the queue head
                        if (!q_stat.empty) begin
                           want_drain = 1'b1;
                        end else begin
                           want_tx = 1'b1;
                        end
                     end else begin
                        peer_new = pseq;
                        clr      = 1'b1;
                        dlv      = 1'b1;
                     end
                  end
               end else if (pcmd == mple_pkg::CMD_ACK) begin
                  if (pack == st.my_seq && pseq == st.peer_seq) begin
                     clr        = 1'b1;
                     want_drain = 1'b1;
                  end
               end else if (pseq != st.peer_seq) begin
                  want_drain = 1'b1;
                  if (pack == st.my_seq) begin
                     clr      = 1'b1;
                     peer_new = pseq;
                     dlv      = 1'b1;
                  end else begin
                     // both sides sent at once: drop our own message
                     flip = 1'b1;
                  end
               end
            end
         end
         mple_pkg::MODE_SEND: begin
            if (st.awaiting && !(send_cmd inside {mple_pkg::CMD_ACK, mple_pkg::CMD_REFUSE,
                                                  mple_pkg::CMD_REPLY})) begin
               if (!q_stat.full) begin
                  q_ctrl.push  = 1'b1;
                  q_ctrl.wdata = {send_cmd, send_val};
               end else begin
                  ovf = 1'b1;
               end
            end else if (send_cmd == mple_pkg::CMD_ACK && !q_stat.empty) begin
               want_drain = 1'b1;
            end else begin
               want_tx = 1'b1;
               tx_cmd  = send_cmd;
               tx_val  = send_val;
            end
         end
         mple_pkg::MODE_TICK: begin
            if (st.awaiting) begin
               if (st.idle_ticks != mple_pkg::IDLE_MAX) begin
                  idle_new = st.idle_ticks + 6'd1;
               end
               nxt.idle_ticks = idle_new;
               if (idle_new > retry_interval) begin
                  if (st.retry_count != mple_pkg::RETRY_MAX) begin
                     retry_new = st.retry_count + 8'd1;
                  end
                  nxt.retry_count = retry_new;
                  if (retry_new > retry_limit) begin
                     tmo = 1'b1;
                  end else begin
                     retx = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (want_drain) begin
         tx_cmd = q_stat.head[12:10];
         tx_val = q_stat.head[9:0];
      end
      q_ctrl.pop = want_drain && !q_stat.empty;
      tx_go      = want_tx || q_ctrl.pop;

      my_mid = st.my_seq ^ flip;
      my_new = tx_go ? (my_mid ^ (tx_cmd != mple_pkg::CMD_ACK)) : my_mid;
      nxt.my_seq   = my_new;
      nxt.peer_seq = peer_new;

      if (clr) begin
         nxt.idle_ticks  = 6'd0;
         nxt.retry_count = 8'd0;
      end

      if (tx_go) begin
         nxt.awaiting = (tx_cmd != mple_pkg::CMD_ACK);
      end else if (want_drain) begin
         nxt.awaiting = 1'b0;
      end

      // framing of an outgoing packet
      b0  = {6'd0, peer_new, my_new};
      b2  = {1'b1, tx_cmd, 1'b0, tx_val[9:7]};
      b3  = {1'b1, tx_val[6:0]};
      b1  = (b0 + b2 + b3) | mple_pkg::TOP_BIT;
      pkt = {b0, b1, b2, b3};

      if (tx_go) begin
         nxt.last_sent = pkt;
      end
   end

   always_comb begin
      dlv_item        = '0;
      dlv_item.kind   = mple_pkg::KIND_DELIVER;
      dlv_item.rx_cmd = pcmd;
      dlv_item.rx_val = pval;

      oth_item = '0;
      if (tx_go) begin
         oth_item.kind      = mple_pkg::KIND_TX;
         oth_item.tx_packet = pkt;
      end else if (retx) begin
         oth_item.kind      = mple_pkg::KIND_TX;
         oth_item.tx_packet = st.last_sent;
      end else if (tmo) begin
         oth_item.kind = mple_pkg::KIND_TIMEOUT;
      end else begin
         oth_item.kind = mple_pkg::KIND_OVERFLOW;
      end
      oth_item.last = 1'b1;
      oth_go = tx_go || retx || tmo || ovf;

      res_n         = {1'b0, dlv} + {1'b0, oth_go};
      res_first     = dlv ? dlv_item : oth_item;
      res_first.last = !(dlv && oth_go);
      res_second    = oth_item;
   end

endmodule

`default_nettype wire

>>> design/mple_send_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mple_send_queue #(
   parameter int QUEUE_DEPTH = mple_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire mple_pkg::queue_ctrl_type q_ctrl,
   output mple_pkg::queue_stat_type     q_stat
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   logic [12:0]   mem [QUEUE_DEPTH];
   logic [12:0]   head_ff;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (q_ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // read ahead at the next head so the front entry is ready every cycle
   always_ff @(posedge clock) begin
      if (q_ctrl.push) begin
         mem[wr_ptr_ff] <= q_ctrl.wdata;
      end
      if (q_ctrl.push && wr_ptr_ff == rd_ptr_in) begin
         head_ff <= q_ctrl.wdata;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == FULL_CNT);
   assign q_stat.head  = head_ff;

endmodule

`default_nettype wire

>>> design/mple_rsp_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module mple_rsp_buf (
   input  wire                         clock,
   input  wire                         reset,
   input  wire [1:0]                   wr_n,
   input  wire mple_pkg::rsp_item_type wr_first,
   input  wire mple_pkg::rsp_item_type wr_second,
   output logic                        space_ok,
   mple_rsp_if.source                  rsp_bus
);

   localparam int PW = mple_pkg::RSP_PW;
   localparam int CW = mple_pkg::RSP_CW;
   localparam logic [CW-1:0] SPACE_CNT = CW'(mple_pkg::RSP_DEPTH - 2);

   mple_pkg::rsp_item_type ent_ff [mple_pkg::RSP_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          pop;
   mple_pkg::rsp_item_type head;

   assign pop  = rsp_bus.valid && rsp_bus.ready;
   assign head = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PW'(wr_n);
         rd_ptr_ff <= rd_ptr_ff + PW'(pop);
         count_ff  <= count_ff + CW'(wr_n) - CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_n != 2'd0) begin
         ent_ff[wr_ptr_ff] <= wr_first;
      end
      if (wr_n == 2'd2) begin
         ent_ff[wr_ptr_ff + 1'b1] <= wr_second;
      end
   end

   // room for the two beats an item may raise
   assign space_ok = (count_ff <= SPACE_CNT);

   assign rsp_bus.valid     = (count_ff != '0);
   assign rsp_bus.kind      = head.kind;
   assign rsp_bus.rx_cmd    = head.rx_cmd;
   assign rsp_bus.rx_val    = head.rx_val;
   assign rsp_bus.tx_packet = head.tx_packet;
   assign rsp_bus.last      = head.last;

endmodule

`default_nettype wire

>>> design/modem_packet_link_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// a req beat that is taken is held in the input register and worked on once the result
// buffer has room; its rsp beats are written into the result buffer and offered from there
// in order, the first beat ahead of the second
// throughput: one req beat per cycle; req stalls while the four-entry result buffer holds
// more than two beats, so sustained rate is bounded by one rsp beat per cycle
// reset: synchronous, active high; clears link state, send queue and result buffer,
// retry_interval returns to 1 and retry_limit to 60

module modem_packet_link_engine #(
   parameter int QUEUE_DEPTH = mple_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   mple_req_if.sink   req_bus,
   mple_rsp_if.source rsp_bus,
   input  wire        csr_we,
   input  wire        csr_index,
   input  wire [7:0]  csr_wdata
);

   logic       in_valid_ff;
   logic [1:0] in_mode_ff;
   logic [7:0] in_byte_ff;
   logic [2:0] in_cmd_ff;
   logic [9:0] in_val_ff;
   logic [5:0] retry_interval_ff;
   logic [7:0] retry_limit_ff;
   logic       space_ok;
   logic       fire;
   logic       take;
   logic [1:0] res_n;
   logic [1:0] wr_n;

   mple_pkg::link_state_type st_ff, st_in;
   mple_pkg::queue_ctrl_type q_ctrl, q_ctrl_gated;
   mple_pkg::queue_stat_type q_stat;
   mple_pkg::rsp_item_type   res_first, res_second;

   assign fire          = in_valid_ff && space_ok;
   assign req_bus.ready = !in_valid_ff || fire;
   assign take          = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_mode_ff <= req_bus.mode;
         in_byte_ff <= req_bus.rx_byte;
         in_cmd_ff  <= req_bus.send_cmd;
         in_val_ff  <= req_bus.send_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_interval_ff <= mple_pkg::RETRY_INTERVAL_RESET;
         retry_limit_ff    <= mple_pkg::RETRY_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mple_pkg::CFG_RETRY_INTERVAL: retry_interval_ff <= csr_wdata[5:0];
            mple_pkg::CFG_RETRY_LIMIT:    retry_limit_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

   mple_core u_core (
      .mode           (in_mode_ff),
      .rx_byte        (in_byte_ff),
      .send_cmd       (in_cmd_ff),
      .send_val       (in_val_ff),
      .retry_interval (retry_interval_ff),
      .retry_limit    (retry_limit_ff),
      .st             (st_ff),
      .q_stat         (q_stat),
      .nxt            (st_in),
      .q_ctrl         (q_ctrl),
      .res_n          (res_n),
      .res_first      (res_first),
      .res_second     (res_second)
   );

   always_comb begin
      q_ctrl_gated      = q_ctrl;
      q_ctrl_gated.push = q_ctrl.push && fire;
      q_ctrl_gated.pop  = q_ctrl.pop && fire;
   end

   mple_send_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_send_queue (
      .clock  (clock),
      .reset  (reset),
      .q_ctrl (q_ctrl_gated),
      .q_stat (q_stat)
   );

   assign wr_n = fire ? res_n : 2'd0;

   mple_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .wr_n      (wr_n),
      .wr_first  (res_first),
      .wr_second (res_second),
      .space_ok  (space_ok),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

>>> tb/sv/tb_modem_packet_link_engine.sv
`timescale 1ns / 1ps

module tb_modem_packet_link_engine;

   localparam logic [1:0] MODE_NONE    = 2'd3;
   localparam logic [2:0] CMD_RESTART  = 3'd2;
   localparam logic [2:0] CMD_ASK      = 3'd3;
   localparam logic [2:0] CMD_PLAY     = 3'd5;
   localparam logic [2:0] CMD_TAKEBACK = 3'd6;
   localparam logic [2:0] CMD_SPARE    = 3'd7;

   localparam int SEND_QUEUE_DEPTH = mple_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int MAX_PRINTS       = 60;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
      logic [2:0] send_cmd;
      logic [9:0] send_val;
   } link_item_type;

   typedef struct {
      link_item_type          item;
      bit                     fixed;
      bit                     fires;
      mple_pkg::rsp_item_type want;
   } script_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;

   mple_req_if req_bus ();
   mple_rsp_if rsp_bus ();

   modem_packet_link_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // link state as the engine should hold it
   logic [5:0]             cfg_interval;
   logic [7:0]             cfg_limit;
   logic [1:0]             asm_count;
   logic [7:0]             asm_bytes [4];
   logic                   own_seq;
   logic                   far_seq;
   logic                   ack_wait;
   logic [5:0]             quiet_ticks;
   logic [7:0]             resend_count;
   logic [31:0]            last_frame;
   logic [12:0]            outgoing_cmds [$];
   mple_pkg::rsp_item_type step_rsp [$];
   mple_pkg::rsp_item_type due_rsp [$];
   script_row_type         directed_rows [$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_request  = 1'b0;
   int hold_left     = 0;
   int mismatches    = 0;

   function automatic logic [7:0] frame_sum(input logic [7:0] b0, b2, b3);
      logic [7:0] s;
      s = b0 + b2 + b3;
      return s | mple_pkg::TOP_BIT;
   endfunction

   function automatic void add_result(input logic [1:0] kind, input logic [2:0] cmd,
                                      input logic [9:0] val, input logic [31:0] frame);
      mple_pkg::rsp_item_type r;
      if (step_rsp.size() >= 2) return;
      r.kind      = kind;
      r.rx_cmd    = cmd;
      r.rx_val    = val;
      r.tx_packet = frame;
      r.last      = 1'b0;
      step_rsp.push_back(r);
   endfunction

   function automatic void send_frame(input logic [2:0] cmd, input logic [9:0] val);
      logic [7:0] b0, b2, b3;
      if (cmd != mple_pkg::CMD_ACK) own_seq = ~own_seq;
      b0 = {6'd0, far_seq, own_seq};
      b2 = mple_pkg::TOP_BIT | {1'b0, cmd, 4'd0} | {5'd0, val[9:7]};
      b3 = mple_pkg::TOP_BIT | {1'b0, val[6:0]};
      last_frame = {b0, frame_sum(b0, b2, b3), b2, b3};
      add_result(mple_pkg::KIND_TX, 3'd0, 10'd0, last_frame);
      ack_wait = (cmd != mple_pkg::CMD_ACK);
   endfunction

   function automatic void send_next_queued();
      logic [12:0] e;
      if (ack_wait || outgoing_cmds.size() == 0) return;
      e = outgoing_cmds.pop_front();
      send_frame(e[12:10], e[9:0]);
   endfunction

   function automatic void host_send(input logic [2:0] cmd, input logic [9:0] val);
      if (ack_wait && cmd != mple_pkg::CMD_ACK && cmd != mple_pkg::CMD_REFUSE &&
          cmd != mple_pkg::CMD_REPLY) begin
         if (outgoing_cmds.size() < SEND_QUEUE_DEPTH) outgoing_cmds.push_back({cmd, val});
         else add_result(mple_pkg::KIND_OVERFLOW, 3'd0, 10'd0, 32'd0);
         return;
      end
      // an ack goes out piggybacked on the queued command
      if (cmd == mple_pkg::CMD_ACK && outgoing_cmds.size() != 0) begin
         ack_wait = 1'b0;
         send_next_queued();
         return;
      end
      send_frame(cmd, val);
   endfunction

   function automatic void take_frame();
      logic       seq, ack;
      logic [2:0] cmd;
      logic [9:0] val;
      seq = asm_bytes[0][0];
      ack = asm_bytes[0][1];
      if ((asm_bytes[2] & mple_pkg::CMD_BIT3) != 0) return;
      cmd = asm_bytes[2][6:4];
      val = {asm_bytes[2][2:0], asm_bytes[3][6:0]};
      if (!ack_wait) begin
         if (cmd == mple_pkg::CMD_ACK || ack != own_seq) return;
         if (seq == far_seq) begin
            host_send(mple_pkg::CMD_ACK, mple_pkg::ACK_VAL);
         end else begin
            far_seq      = seq;
            quiet_ticks  = 6'd0;
            resend_count = 8'd0;
            add_result(mple_pkg::KIND_DELIVER, cmd, val, 32'd0);
         end
         return;
      end
      if (cmd == mple_pkg::CMD_ACK) begin
         if (ack != own_seq || seq != far_seq) return;
         quiet_ticks  = 6'd0;
         resend_count = 8'd0;
         ack_wait     = 1'b0;
         send_next_queued();
      end else if (seq != far_seq) begin
         if (ack == own_seq) begin
            quiet_ticks  = 6'd0;
            resend_count = 8'd0;
            ack_wait     = 1'b0;
            far_seq      = seq;
            add_result(mple_pkg::KIND_DELIVER, cmd, val, 32'd0);
         end else begin
            // both sides sent at once: ours is given up
            own_seq  = ~own_seq;
            ack_wait = 1'b0;
         end
         send_next_queued();
      end
   endfunction

   function automatic void take_byte(input logic [7:0] c);
      if (asm_count == 2'd0) begin
         if ((c & mple_pkg::START_MASK) == 0) begin
            asm_bytes[0] = c;
            asm_count    = 2'd1;
         end
         return;
      end
      if ((c & mple_pkg::TOP_BIT) == 0) begin
         asm_count = 2'd0;
         if ((c & mple_pkg::START_MASK) == 0) begin
            asm_bytes[0] = c;
            asm_count    = 2'd1;
         end
         return;
      end
      asm_bytes[asm_count] = c;
      if (asm_count == 2'd3) begin
         asm_count = 2'd0;
         if (frame_sum(asm_bytes[0], asm_bytes[2], asm_bytes[3]) == asm_bytes[1]) take_frame();
      end else begin
         asm_count = asm_count + 2'd1;
      end
   endfunction

   function automatic void take_tick();
      if (!ack_wait) return;
      if (quiet_ticks < mple_pkg::IDLE_MAX) quiet_ticks = quiet_ticks + 6'd1;
      if (quiet_ticks > cfg_interval) begin
         if (resend_count < mple_pkg::RETRY_MAX) resend_count = resend_count + 8'd1;
         if (resend_count > cfg_limit)
            add_result(mple_pkg::KIND_TIMEOUT, 3'd0, 10'd0, 32'd0);
         else
            add_result(mple_pkg::KIND_TX, 3'd0, 10'd0, last_frame);
      end
   endfunction

   function automatic void link_predict(input link_item_type it);
      step_rsp.delete();
      case (it.mode)
         mple_pkg::MODE_RX:   take_byte(it.rx_byte);
         mple_pkg::MODE_SEND: host_send(it.send_cmd, it.send_val);
         mple_pkg::MODE_TICK: take_tick();
         default:             ;
      endcase
      if (step_rsp.size() != 0) step_rsp[step_rsp.size() - 1].last = 1'b1;
   endfunction

   function automatic link_item_type any_item(input logic [1:0] mode);
      link_item_type it;
      it.mode     = mode;
      it.rx_byte  = 8'($urandom_range(255));
      it.send_cmd = 3'($urandom_range(7));
      it.send_val = 10'($urandom_range(1023));
      return it;
   endfunction

   function automatic link_item_type plain(input logic [1:0] mode, input logic [7:0] rx_byte,
                                           input logic [2:0] cmd, input logic [9:0] val);
      link_item_type it;
      it.mode     = mode;
      it.rx_byte  = rx_byte;
      it.send_cmd = cmd;
      it.send_val = val;
      return it;
   endfunction

   // commands that wait in the send queue while an ack is outstanding
   function automatic logic [2:0] deferred_cmd();
      case ($urandom_range(3))
         0:       return CMD_RESTART;
         1:       return CMD_ASK;
         2:       return CMD_PLAY;
         default: return CMD_TAKEBACK;
      endcase
   endfunction

   function automatic logic [31:0] peer_frame(input logic seq, ack, input logic [2:0] cmd,
                                              input logic [9:0] val, input bit bad_sum,
                                              input bit cmd_bit3);
      logic [7:0] b0, b1, b2, b3;
      b0 = {6'd0, ack, seq};
      b2 = mple_pkg::TOP_BIT | {1'b0, cmd, 4'd0} | {5'd0, val[9:7]};
      if (cmd_bit3) b2 = b2 | mple_pkg::CMD_BIT3;
      b3 = mple_pkg::TOP_BIT | {1'b0, val[6:0]};
      b1 = frame_sum(b0, b2, b3);
      if (bad_sum) b1 = b1 ^ (8'd1 << $urandom_range(6));
      return {b0, b1, b2, b3};
   endfunction

   function automatic void script_row(input link_item_type it, input bit fixed, input bit fires,
                                      input mple_pkg::rsp_item_type want);
      script_row_type row;
      row.item  = it;
      row.fixed = fixed;
      row.fires = fires;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void script_frame(input logic [31:0] frame);
      for (int k = 0; k < 4; k++)
         script_row(plain(mple_pkg::MODE_RX, frame[31 - 8 * k -: 8], mple_pkg::CMD_ACK, 10'd0),
                    1'b0, 1'b0, '0);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_PRINTS)
         $display("%0t %s: got %h, want %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic offer(input link_item_type it, input bit keep);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= it.mode;
      req_bus.rx_byte  <= it.rx_byte;
      req_bus.send_cmd <= it.send_cmd;
      req_bus.send_val <= it.send_val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      link_predict(it);
      if (keep) foreach (step_rsp[i]) due_rsp.push_back(step_rsp[i]);
   endtask

   task automatic offer_bytes(input logic [31:0] frame, input int count);
      link_item_type it;
      for (int k = 0; k < count; k++) begin
         it         = any_item(mple_pkg::MODE_RX);
         it.rx_byte = frame[31 - 8 * k -: 8];
         offer(it, 1'b1);
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_timing(input logic [5:0] interval, input logic [7:0] limit);
      logic [1:0] pad;
      pad = 2'($urandom_range(3));
      csr_we    <= 1'b1;
      csr_index <= mple_pkg::CFG_RETRY_INTERVAL;
      csr_wdata <= {pad, interval};
      @(posedge clock);
      cfg_interval = interval;
      csr_index <= mple_pkg::CFG_RETRY_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      cfg_limit = limit;
      csr_we <= 1'b0;
   endtask

   task automatic flood_queue();
      link_item_type it;
      repeat (SEND_QUEUE_DEPTH + 2) begin
         it          = any_item(mple_pkg::MODE_SEND);
         it.send_cmd = deferred_cmd();
         offer(it, 1'b1);
      end
   endtask

   task automatic random_traffic(input int n);
      int            made;
      int            pick;
      int            flaw;
      link_item_type it;
      logic          seq, ack;
      logic [2:0]    cmd;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(99);
         if (pick < 42) begin
            // mostly frames the engine will act on, with some damaged or cut short
            cmd = 3'($urandom_range(7));
            if (cmd == mple_pkg::CMD_ACK) seq = ($urandom_range(9) < 8) ? far_seq : ~far_seq;
            else seq = ($urandom_range(9) < 7) ? ~far_seq : far_seq;
            ack  = ($urandom_range(9) < 8) ? own_seq : ~own_seq;
            flaw = $urandom_range(19);
            offer_bytes(peer_frame(seq, ack, cmd, 10'($urandom_range(1023)),
                                   flaw == 0, flaw == 1),
                        (flaw == 2) ? $urandom_range(3, 1) : 4);
            made += 4;
         end else if (pick < 68) begin
            it = any_item(mple_pkg::MODE_SEND);
            if ($urandom_range(1) == 1) it.send_cmd = deferred_cmd();
            if (it.send_cmd == mple_pkg::CMD_ACK && $urandom_range(1) == 1)
               it.send_val = mple_pkg::ACK_VAL;
            offer(it, 1'b1);
            made++;
         end else if (pick < 90) begin
            offer(any_item(mple_pkg::MODE_TICK), 1'b1);
            made++;
         end else if (pick < 97) begin
            offer(any_item(mple_pkg::MODE_RX), 1'b1);
            made++;
         end else begin
            offer(any_item(MODE_NONE), 1'b1);
         end
      end
   endtask

   task automatic run_phase(input logic [5:0] interval, input logic [7:0] limit,
                            input int idle_pct, input int stall, input int n);
      settle();
      set_timing(interval, limit);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      flood_queue();
      random_traffic(n);
   endtask

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      mple_pkg::rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_rsp.size() == 0) begin
            report_mismatch("result beat with nothing due", rsp_bus.tx_packet, 32'd0);
         end else begin
            want = due_rsp.pop_front();
            if (rsp_bus.kind != want.kind)
               report_mismatch("kind", 32'(rsp_bus.kind), 32'(want.kind));
            if (rsp_bus.rx_cmd != want.rx_cmd)
               report_mismatch("rx_cmd", 32'(rsp_bus.rx_cmd), 32'(want.rx_cmd));
            if (rsp_bus.rx_val != want.rx_val)
               report_mismatch("rx_val", 32'(rsp_bus.rx_val), 32'(want.rx_val));
            if (rsp_bus.tx_packet != want.tx_packet)
               report_mismatch("tx_packet", rsp_bus.tx_packet, want.tx_packet);
            if (rsp_bus.last != want.last)
               report_mismatch("last", 32'(rsp_bus.last), 32'(want.last));
         end
      end
   end

   initial begin
      #4_000_000;
      $display("FAIL modem_packet_link_engine");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.mode     = mple_pkg::MODE_RX;
      req_bus.rx_byte  = 8'd0;
      req_bus.send_cmd = mple_pkg::CMD_ACK;
      req_bus.send_val = 10'd0;
      rsp_bus.ready    = 1'b0;
      csr_we           = 1'b0;
      csr_index        = mple_pkg::CFG_RETRY_INTERVAL;
      csr_wdata        = 8'd0;
      cfg_interval     = mple_pkg::RETRY_INTERVAL_RESET;
      cfg_limit        = mple_pkg::RETRY_LIMIT_RESET;
      asm_count        = 2'd0;
      own_seq          = 1'b0;
      far_seq          = 1'b0;
      ack_wait         = 1'b0;
      quiet_ticks      = 6'd0;
      resend_count     = 8'd0;
      last_frame       = 32'd0;

      // opening script at the reset timing
      script_row(plain(mple_pkg::MODE_TICK, 8'h00, mple_pkg::CMD_ACK, 10'd0), 1'b1, 1'b0, '0);
      script_row(plain(MODE_NONE, 8'hff, CMD_SPARE, 10'h3ff), 1'b1, 1'b0, '0);
      script_row(plain(mple_pkg::MODE_SEND, 8'h00, CMD_ASK, 10'h3ff), 1'b1, 1'b1,
                 mple_pkg::rsp_item_type'{mple_pkg::KIND_TX, 3'd0, 10'd0, 32'h01b7b7ff,
                                          1'b1});
      script_row(plain(mple_pkg::MODE_SEND, 8'hff, CMD_PLAY, 10'd0), 1'b1, 1'b0, '0);
      script_row(plain(mple_pkg::MODE_SEND, 8'h00, mple_pkg::CMD_REFUSE, 10'd0),
                 1'b0, 1'b0, '0);
      script_row(plain(mple_pkg::MODE_TICK, 8'h00, mple_pkg::CMD_ACK, 10'd0), 1'b0, 1'b0, '0);
      script_row(plain(mple_pkg::MODE_TICK, 8'h00, mple_pkg::CMD_ACK, 10'd0), 1'b0, 1'b0, '0);
      script_row(plain(mple_pkg::MODE_SEND, 8'h00, mple_pkg::CMD_ACK, mple_pkg::ACK_VAL),
                 1'b0, 1'b0, '0);
      // half a frame cut off by the start of the next
      script_row(plain(mple_pkg::MODE_RX, 8'h00, mple_pkg::CMD_ACK, 10'd0), 1'b0, 1'b0, '0);
      script_row(plain(mple_pkg::MODE_RX, 8'h80, mple_pkg::CMD_ACK, 10'd0), 1'b0, 1'b0, '0);
      script_frame(peer_frame(1'b1, 1'b1, CMD_SPARE, 10'h3ff, 1'b0, 1'b0));
      script_frame(peer_frame(1'b0, 1'b1, CMD_RESTART, 10'd0, 1'b1, 1'b0));
      script_frame(peer_frame(1'b0, 1'b1, CMD_TAKEBACK, 10'h155, 1'b0, 1'b1));
      script_row(plain(mple_pkg::MODE_SEND, 8'h00, mple_pkg::CMD_REPLY, 10'h3ff),
                 1'b0, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer(directed_rows[i].item, !directed_rows[i].fixed);
         if (directed_rows[i].fixed && directed_rows[i].fires)
            due_rsp.push_back(directed_rows[i].want);
      end

      // result side held off while refusals keep coming, then a full drain
      settle();
      set_timing(mple_pkg::RETRY_INTERVAL_RESET, mple_pkg::RETRY_LIMIT_RESET);
      hold_request = 1'b1;
      repeat (30)
         offer(plain(mple_pkg::MODE_SEND, 8'h00, mple_pkg::CMD_REFUSE,
                     10'($urandom_range(1023))), 1'b1);
      settle();
      random_traffic(40);

      run_phase(6'd0, 8'd0, 47, 0, 45);
      run_phase(6'd63, 8'd255, 0, 47, 45);
      run_phase(6'd3, 8'd5, 36, 36, 45);

      // retry counter runs into saturation, timeouts from then on
      settle();
      set_timing(6'd0, 8'd254);
      send_idle_pct = 0;
      stall_pct     = 47;
      offer(plain(mple_pkg::MODE_SEND, 8'h00, CMD_ASK, 10'($urandom_range(1023))), 1'b1);
      repeat (258) offer(any_item(mple_pkg::MODE_TICK), 1'b1);

      settle();
      if (mismatches == 0) begin
         $display("PASS modem_packet_link_engine");
      end else begin
         $display("FAIL modem_packet_link_engine");
      end
      $finish;
   end

endmodule
